// ===== rtl/sqlss_pkg.sv =====
`timescale 1ns / 1ps

package sqlss_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int LEN_W         = 16;
  localparam int CHAR_W        = 8;
  localparam int NUM_W         = 16;
  localparam int MAX_RES       = 3;

  localparam logic [LEN_W-1:0] LEN_TOP = '1;

  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_SQUOT = 8'h27;
  localparam logic [CHAR_W-1:0] CH_DQUOT = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Scanner state carried from one item to the next
  typedef struct packed {
    logic              sq;
    logic              dq;
    logic              bc;
    logic              skip;
    logic [CHAR_W-1:0] prev;
    logic              prev_app;
    logic [CHAR_W-1:0] held;
    logic              held_v;
    logic [LEN_W-1:0]  len;
  } scan_st_t;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] ch;
    logic [NUM_W-1:0]  line;
    logic              last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         n;
  } burst_t;

endpackage

// ===== rtl/sql_script_statement_splitter_unit.sv =====
`timescale 1ns / 1ps

// SQL script statement splitter. Items (a script byte or a line-end event) enter
// an input register; one pass of flag logic then strips comments, collapses
// spaces, tracks quoted literals and loads the zero to three results of the item
// into a three-entry result buffer, which drains one result per cycle while
// out_ready is high. A new item is taken every cycle while items cause at most
// one result and out_ready is high; after an item with more results, the next
// item waits until the buffer drains its last entry. Each result passes through
// the input register and the result buffer. A semicolon outside literals and
// comments gives a statement-end result with the low 16 bits of its line number.
module sql_script_statement_splitter_unit #(
  parameter int LINE_BITS = sqlss_pkg::LINE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_is_line_end,
  input  logic [sqlss_pkg::CHAR_W-1:0]  in_text_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [sqlss_pkg::CHAR_W-1:0]  out_char,
  output logic [sqlss_pkg::NUM_W-1:0]   out_line_number,
  output logic                          out_last
);

  logic                                     item_vld_r;
  logic                                     item_le_r;
  logic [sqlss_pkg::CHAR_W-1:0]             item_ch_r;
  sqlss_pkg::scan_st_t                      st_r;
  sqlss_pkg::scan_st_t                      st_nxt;
  logic [LINE_BITS-1:0]                     line_r;
  logic [LINE_BITS-1:0]                     line_nxt;
  sqlss_pkg::burst_t                        burst;
  sqlss_pkg::res_t [sqlss_pkg::MAX_RES-1:0] res_r;
  logic [1:0]                               cnt_r;
  logic                                     pop;
  logic                                     take;

  assign pop      = out_valid & out_ready;
  // hand the item to the result buffer once it is empty or draining its last entry
  assign take     = item_vld_r & ((cnt_r == 2'd0) | ((cnt_r == 2'd1) & out_ready));
  assign in_ready = ~item_vld_r | take;

  sqlss_step #(
    .LINE_BITS (LINE_BITS)
  ) u_step (
    .is_line_end (item_le_r),
    .text_char   (item_ch_r),
    .st_i        (st_r),
    .line_i      (line_r),
    .st_o        (st_nxt),
    .line_o      (line_nxt),
    .burst_o     (burst)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_le_r <= in_is_line_end;
      item_ch_r <= in_text_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      line_r <= LINE_BITS'(1);
    end else if (take) begin
      st_r   <= st_nxt;
      line_r <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (take) begin
      cnt_r <= burst.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= burst.res;
    end else if (pop) begin
      // advance the queue by one entry
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_kind        = res_r[0].kind;
  assign out_char        = res_r[0].ch;
  assign out_line_number = res_r[0].line;
  assign out_last        = res_r[0].last;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (take && cnt_r != 2'd0) |-> (cnt_r == 2'd1 && out_ready))
    else $error("result buffer overwritten while results pending");

  a_tail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> res_r[0].last)
    else $error("final buffered result not marked last");

  a_held_counted: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.held_v |-> (st_r.len != '0))
    else $error("held character not counted in statement length");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == sqlss_pkg::KIND_END) |-> (out_char == '0))
    else $error("statement end carries a character");

endmodule

// ===== rtl/sqlss_step.sv =====
`timescale 1ns / 1ps

module sqlss_step #(
  parameter int LINE_BITS = sqlss_pkg::LINE_BITS_DEF
) (
  input  logic                          is_line_end,
  input  logic [sqlss_pkg::CHAR_W-1:0]  text_char,
  input  sqlss_pkg::scan_st_t           st_i,
  input  logic [LINE_BITS-1:0]          line_i,
  output sqlss_pkg::scan_st_t           st_o,
  output logic [LINE_BITS-1:0]          line_o,
  output sqlss_pkg::burst_t             burst_o
);

  logic                 in_lit;
  logic                 app;
  logic                 drp;
  logic                 eos;
  logic                 emit_held;
  logic                 nl;
  sqlss_pkg::res_t      rec_h;
  sqlss_pkg::res_t      rec_e;
  sqlss_pkg::res_t      rec_nl;
  sqlss_pkg::res_t      rec_sp;
  sqlss_pkg::res_t      rec_z;

  assign in_lit = st_i.sq | st_i.dq;

  always_comb begin
    st_o      = st_i;
    line_o    = line_i;
    app       = 1'b0;
    drp       = 1'b0;
    eos       = 1'b0;
    emit_held = 1'b0;
    nl        = 1'b0;
    if (is_line_end) begin
      emit_held   = st_i.held_v;
      nl          = (st_i.len != '0);
      st_o.held_v = 1'b0;
      if (nl) begin
        st_o.len = (st_i.len > sqlss_pkg::LEN_TOP - sqlss_pkg::LEN_W'(2)) ?
                   sqlss_pkg::LEN_TOP : st_i.len + sqlss_pkg::LEN_W'(2);
      end
      if (line_i != '1) begin
        line_o = line_i + LINE_BITS'(1);
      end
      st_o.prev     = '0;
      st_o.prev_app = 1'b0;
      st_o.skip     = 1'b0;
    end else if (!st_i.skip) begin
      unique case (text_char)
        sqlss_pkg::CH_DASH: begin
          if (!in_lit && !st_i.bc && st_i.prev == sqlss_pkg::CH_DASH) begin
            drp       = 1'b1;
            st_o.skip = 1'b1;
          end else if (!st_i.bc) begin
            app = 1'b1;
          end
        end
        sqlss_pkg::CH_SLASH: begin
          if (!in_lit && st_i.bc && st_i.prev == sqlss_pkg::CH_STAR) begin
            st_o.bc = 1'b0;
          end else if (!st_i.bc) begin
            app = 1'b1;
          end
        end
        sqlss_pkg::CH_STAR: begin
          // open a comment only after a slash that joined the statement
          if (!in_lit && st_i.prev == sqlss_pkg::CH_SLASH && st_i.prev_app) begin
            drp     = 1'b1;
            st_o.bc = 1'b1;
          end else if (!st_i.bc) begin
            app = 1'b1;
          end
        end
        sqlss_pkg::CH_SQUOT: begin
          if (!st_i.bc && !st_i.dq) begin
            st_o.sq = ~st_i.sq;
            app     = 1'b1;
          end else if (st_i.dq) begin
            app = 1'b1;
          end
        end
        sqlss_pkg::CH_DQUOT: begin
          if (!st_i.bc && !st_i.sq) begin
            st_o.dq = ~st_i.dq;
            app     = 1'b1;
          end else if (st_i.sq) begin
            app = 1'b1;
          end
        end
        sqlss_pkg::CH_SEMI: begin
          if (in_lit) begin
            app = 1'b1;
          end else if (!st_i.bc) begin
            eos = 1'b1;
          end
        end
        default: begin
          if (!st_i.bc) begin
            if (in_lit) begin
              app = 1'b1;
            end else if (!(text_char == sqlss_pkg::CH_SPACE &&
                           (st_i.prev == sqlss_pkg::CH_SPACE || st_i.len == '0))) begin
              app = 1'b1;
            end
          end
        end
      endcase

      if (app) begin
        emit_held   = st_i.held_v;
        st_o.held   = text_char;
        st_o.held_v = 1'b1;
        if (st_i.len != sqlss_pkg::LEN_TOP) begin
          st_o.len = st_i.len + sqlss_pkg::LEN_W'(1);
        end
      end
      if (drp) begin
        st_o.held_v = 1'b0;
        if (st_i.len != '0) begin
          st_o.len = st_i.len - sqlss_pkg::LEN_W'(1);
        end
      end
      if (eos) begin
        emit_held   = st_i.held_v;
        st_o.held_v = 1'b0;
        st_o.len    = '0;
        st_o.sq     = 1'b0;
        st_o.dq     = 1'b0;
        st_o.bc     = 1'b0;
      end
      st_o.prev     = text_char;
      st_o.prev_app = app;
    end
  end

  always_comb begin
    rec_h  = '{kind: sqlss_pkg::KIND_CHAR, ch: st_i.held, line: '0, last: 1'b0};
    rec_e  = '{kind: sqlss_pkg::KIND_END, ch: '0,
               line: sqlss_pkg::NUM_W'(line_i), last: 1'b0};
    rec_nl = '{kind: sqlss_pkg::KIND_CHAR, ch: sqlss_pkg::CH_NL, line: '0, last: 1'b0};
    rec_sp = '{kind: sqlss_pkg::KIND_CHAR, ch: sqlss_pkg::CH_SPACE, line: '0, last: 1'b0};
    rec_z  = '0;
    burst_o.res = {rec_z, rec_z, rec_z};
    burst_o.n   = 2'd0;
    if (is_line_end) begin
      unique case ({emit_held, nl})
        2'b11: begin
          burst_o.res = {rec_sp, rec_nl, rec_h};
          burst_o.n   = 2'd3;
        end
        2'b01: begin
          burst_o.res = {rec_z, rec_sp, rec_nl};
          burst_o.n   = 2'd2;
        end
        2'b10: begin
          burst_o.res = {rec_z, rec_z, rec_h};
          burst_o.n   = 2'd1;
        end
        default: begin
          burst_o.n = 2'd0;
        end
      endcase
    end else begin
      unique case ({emit_held, eos})
        2'b11: begin
          burst_o.res = {rec_z, rec_e, rec_h};
          burst_o.n   = 2'd2;
        end
        2'b10: begin
          burst_o.res = {rec_z, rec_z, rec_h};
          burst_o.n   = 2'd1;
        end
        2'b01: begin
          burst_o.res = {rec_z, rec_z, rec_e};
          burst_o.n   = 2'd1;
        end
        default: begin
          burst_o.n = 2'd0;
        end
      endcase
    end
    // mark the final result of this item
    for (int i = 0; i < sqlss_pkg::MAX_RES; i++) begin
      if (2'(i) + 2'd1 == burst_o.n) begin
        burst_o.res[i].last = 1'b1;
      end
    end
  end

endmodule

// ===== verif/sql_script_statement_splitter_unit_tb.sv =====
`timescale 1ns / 1ps

module sql_script_statement_splitter_unit_tb;

  localparam int     LINE_BITS   = sqlss_pkg::LINE_BITS_DEF;
  localparam longint LINE_TOP    = (64'd1 << LINE_BITS) - 1;
  localparam int     HOLD_CYCLES = 250;
  localparam int     RAND_ITEMS  = 280;

  typedef struct {
    logic                         le;
    logic [sqlss_pkg::CHAR_W-1:0] ch;
    int                           gap;
  } script_item_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_is_line_end = 1'b0;
  logic [sqlss_pkg::CHAR_W-1:0] in_text_char = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         out_kind;
  logic [sqlss_pkg::CHAR_W-1:0] out_char;
  logic [sqlss_pkg::NUM_W-1:0]  out_line_number;
  logic                         out_last;

  sql_script_statement_splitter_unit #(
    .LINE_BITS(LINE_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_is_line_end (in_is_line_end),
    .in_text_char   (in_text_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_char       (out_char),
    .out_line_number(out_line_number),
    .out_last       (out_last)
  );

  // Scanner state of the predictor
  bit                           sq_open, dq_open, cmt_open, skip_line;
  bit                           prev_joined, held_v, joined_now;
  logic [sqlss_pkg::CHAR_W-1:0] prev_ch = '0;
  logic [sqlss_pkg::CHAR_W-1:0] held_ch = '0;
  int unsigned                  stmt_len = 0;
  longint                       line_no = 1;

  sqlss_pkg::res_t burst[$];
  sqlss_pkg::res_t due_results[$];
  script_item_t    script_q[$];
  script_item_t    cur;

  bit in_took, out_took, cur_loaded, tx_quiet, rx_quiet, hold_done;
  int gap_left, wait_left, hold_left;
  int n_queued, n_taken, n_results, n_ends, n_line_ends, n_err;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still due", due_results.size());
    $display("sql_script_statement_splitter_unit_tb failed");
    $finish;
  end

  function automatic void emit(logic kind, logic [sqlss_pkg::CHAR_W-1:0] ch,
                               logic [sqlss_pkg::NUM_W-1:0] line);
    sqlss_pkg::res_t r;
    r.kind = kind;
    r.ch   = ch;
    r.line = line;
    r.last = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void flush_held();
    if (held_v) emit(sqlss_pkg::KIND_CHAR, held_ch, '0);
    held_v = 1'b0;
  endfunction

  function automatic void join_char(logic [sqlss_pkg::CHAR_W-1:0] c);
    flush_held();
    held_ch = c;
    held_v  = 1'b1;
    if (stmt_len < 32'(sqlss_pkg::LEN_TOP)) stmt_len++;
    joined_now = 1'b1;
  endfunction

  // A comment opener takes back the held character
  function automatic void unhold();
    held_v = 1'b0;
    if (stmt_len > 0) stmt_len--;
  endfunction

  function automatic void scan_char(logic [sqlss_pkg::CHAR_W-1:0] c);
    bit in_lit;
    in_lit = sq_open || dq_open;
    case (c)
      sqlss_pkg::CH_DASH: begin
        if (!in_lit && !cmt_open && prev_ch == sqlss_pkg::CH_DASH) begin
          unhold();
          skip_line = 1'b1;
        end else if (!cmt_open) begin
          join_char(c);
        end
      end
      sqlss_pkg::CH_SLASH: begin
        if (!in_lit && cmt_open && prev_ch == sqlss_pkg::CH_STAR) cmt_open = 1'b0;
        else if (!cmt_open) join_char(c);
      end
      sqlss_pkg::CH_STAR: begin
        // only a slash that joined the statement opens a comment
        if (!in_lit && prev_ch == sqlss_pkg::CH_SLASH && prev_joined) begin
          unhold();
          cmt_open = 1'b1;
        end else if (!cmt_open) begin
          join_char(c);
        end
      end
      sqlss_pkg::CH_SQUOT: begin
        if (!cmt_open && !dq_open) begin
          sq_open = !sq_open;
          join_char(c);
        end else if (dq_open) begin
          join_char(c);
        end
      end
      sqlss_pkg::CH_DQUOT: begin
        if (!cmt_open && !sq_open) begin
          dq_open = !dq_open;
          join_char(c);
        end else if (sq_open) begin
          join_char(c);
        end
      end
      sqlss_pkg::CH_SEMI: begin
        if (in_lit) begin
          join_char(c);
        end else if (!cmt_open) begin
          flush_held();
          emit(sqlss_pkg::KIND_END, '0, line_no[sqlss_pkg::NUM_W-1:0]);
          n_ends++;
          stmt_len = 0;
          sq_open  = 1'b0;
          dq_open  = 1'b0;
        end
      end
      default: begin
        if (!cmt_open) begin
          if (in_lit) join_char(c);
          else if (!(c == sqlss_pkg::CH_SPACE &&
                     (prev_ch == sqlss_pkg::CH_SPACE || stmt_len == 0))) join_char(c);
        end
      end
    endcase
  endfunction

  function automatic void scan_item(logic le, logic [sqlss_pkg::CHAR_W-1:0] c);
    burst.delete();
    if (le) begin
      n_line_ends++;
      flush_held();
      if (stmt_len > 0) begin
        emit(sqlss_pkg::KIND_CHAR, sqlss_pkg::CH_NL, '0);
        emit(sqlss_pkg::KIND_CHAR, sqlss_pkg::CH_SPACE, '0);
        stmt_len = (stmt_len > 32'(sqlss_pkg::LEN_TOP) - 32'd2) ?
                   32'(sqlss_pkg::LEN_TOP) : stmt_len + 32'd2;
      end
      if (line_no < LINE_TOP) line_no++;
      prev_ch     = '0;
      prev_joined = 1'b0;
      skip_line   = 1'b0;
    end else if (!skip_line) begin
      joined_now = 1'b0;
      scan_char(c);
      prev_ch     = c;
      prev_joined = joined_now;
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) due_results.push_back(burst[i]);
  endfunction

  function automatic void check_field(string name, logic [sqlss_pkg::NUM_W-1:0] want,
                                      logic [sqlss_pkg::NUM_W-1:0] got);
    if (got !== want) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    sqlss_pkg::res_t want;
    in_took  = rst_n && in_valid && in_ready;
    out_took = rst_n && out_valid && out_ready;
    if (in_took) begin
      scan_item(in_is_line_end, in_text_char);
      n_taken++;
    end
    if (out_took) begin
      n_results++;
      if (due_results.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result, expected none, actual kind %0h char %0h line %0d",
                 $time, out_kind, out_char, out_line_number);
      end else begin
        want = due_results.pop_front();
        check_field("kind", sqlss_pkg::NUM_W'(want.kind), sqlss_pkg::NUM_W'(out_kind));
        check_field("char", sqlss_pkg::NUM_W'(want.ch), sqlss_pkg::NUM_W'(out_char));
        check_field("line_number", want.line, out_line_number);
        check_field("last", sqlss_pkg::NUM_W'(want.last), sqlss_pkg::NUM_W'(out_last));
      end
    end
  end

  // Sender: each item waits out its own gap before being offered
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_took) cur_loaded = 1'b0;
      if (!cur_loaded && script_q.size() > 0) begin
        cur        = script_q.pop_front();
        cur_loaded = 1'b1;
        gap_left   = cur.gap;
      end
      if (cur_loaded && gap_left == 0) begin
        in_valid       <= 1'b1;
        in_is_line_end <= cur.le;
        in_text_char   <= cur.ch;
      end else begin
        in_valid <= 1'b0;
        if (cur_loaded) gap_left--;
      end
    end
  end

  // Receiver: random stall per result, plus one long hold-off to fill the block
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && n_taken >= 60) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (out_took) begin
        if ($urandom_range(0, 24) == 0) rx_quiet = !rx_quiet;
        wait_left = rx_quiet ? 0 : $urandom_range(0, 15);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(logic le, logic [sqlss_pkg::CHAR_W-1:0] c);
    script_item_t it;
    it.le  = le;
    it.ch  = c;
    it.gap = tx_quiet ? 0 : $urandom_range(0, 15);
    script_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_ch(logic [sqlss_pkg::CHAR_W-1:0] c);
    push_item(1'b0, c);
  endtask

  // A newline in the text stands for a line-end item
  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == sqlss_pkg::CH_NL) push_item(1'b1, sqlss_pkg::CHAR_W'($urandom_range(0, 255)));
      else push_ch(s[i]);
    end
  endtask

  function automatic logic [sqlss_pkg::CHAR_W-1:0] word_char();
    return ($urandom_range(0, 3) == 0) ? sqlss_pkg::CH_SPACE :
           sqlss_pkg::CHAR_W'(8'h61 + $urandom_range(0, 25));
  endfunction

  function automatic logic [sqlss_pkg::CHAR_W-1:0] any_char();
    logic [sqlss_pkg::CHAR_W-1:0] marks[7];
    marks = '{sqlss_pkg::CH_DASH, sqlss_pkg::CH_SLASH, sqlss_pkg::CH_STAR, sqlss_pkg::CH_SEMI,
              sqlss_pkg::CH_SQUOT, sqlss_pkg::CH_DQUOT, sqlss_pkg::CH_SPACE};
    case ($urandom_range(0, 3))
      0, 1:    return marks[$urandom_range(0, 6)];
      2:       return word_char();
      default: return sqlss_pkg::CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_fragment();
    int n;
    n = $urandom_range(1, 8);
    if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        repeat (n) push_ch(word_char());
        if ($urandom_range(0, 1)) push_ch(sqlss_pkg::CH_SEMI);
      end
      3: begin
        push_text("/*");
        repeat (n) push_ch(any_char());
        push_text("*/");
      end
      4: begin
        push_text("--");
        repeat (n) push_ch(any_char());
        push_item(1'b1, sqlss_pkg::CHAR_W'($urandom_range(0, 255)));
      end
      5: begin
        push_ch(sqlss_pkg::CH_SQUOT);
        repeat (n) push_ch(any_char());
        push_ch(sqlss_pkg::CH_SQUOT);
      end
      6: begin
        push_ch(sqlss_pkg::CH_DQUOT);
        repeat (n) push_ch(any_char());
        push_ch(sqlss_pkg::CH_DQUOT);
      end
      7: push_ch(sqlss_pkg::CH_SEMI);
      8: push_item(1'b1, sqlss_pkg::CHAR_W'($urandom_range(0, 255)));
      default: repeat (n) push_item(1'($urandom_range(0, 1)),
                                    sqlss_pkg::CHAR_W'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic drain();
    while (n_taken != n_queued || due_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // leading and repeated spaces, a line comment hiding a semicolon
    push_text("  a  b--;\n");
    // semicolon and a nested opener inside a block comment, then a star after the closer
    push_text("/*;/**/*");
    // comment marks and semicolon inside a literal
    push_text("'/*;';");
    push_ch(8'hFF);
    push_item(1'b1, 8'hFF);

    while (n_queued < RAND_ITEMS) push_fragment();
    drain();

    // close whatever is open and finish with two short statements
    tx_quiet = 1'b1;
    push_item(1'b1, '0);
    if (sq_open) push_ch(sqlss_pkg::CH_SQUOT);
    if (dq_open) push_ch(sqlss_pkg::CH_DQUOT);
    if (cmt_open) push_text("*/");
    push_ch(sqlss_pkg::CH_SEMI);
    push_text(";x;\n");
    drain();

    repeat (10) @(negedge clk);
    if (due_results.size() != 0) begin
      n_err++;
      $display("%0t: %0d expected results never arrived", $time, due_results.size());
    end
    $display("covered %0d items (%0d line ends), %0d results, %0d statement ends",
             n_taken, n_line_ends, n_results, n_ends);
    $display("comments, literals, space folding and a %0d-cycle output stall",
             HOLD_CYCLES);
    if (n_err == 0) begin
      $display("sql_script_statement_splitter_unit_tb passed");
    end else begin
      $display("sql_script_statement_splitter_unit_tb failed");
    end
    $finish;
  end

endmodule
